// File: hw/rtl/crbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crbc_pkg
// Shared types and constants for the clock replacement block cache.
// ----------------------------------------------------------------------------
package crbc_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int ID_W    = 31;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [ADDR_W-1:0] REG_ACTIVE_ENTRIES = 3'd0;

  typedef struct packed {
    logic            mode;
    logic [ID_W-1:0] block_num;
  } request_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              replaced;
    logic [ID_W-1:0]   evicted_block;
  } result_t;

endpackage

// File: hw/rtl/clock_replacement_block_cache_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_block_cache_core
// Fully associative block-cache directory with clock (second-chance)
// replacement; tags in a synchronous RAM, reference bits in flops.
// ----------------------------------------------------------------------------
// One request is in work at a time; busy is high until its result goes out.
// The tag RAM is read one slot per cycle, so a hit on slot k is found after
// the slots below it have been compared. A miss scans every filled slot first;
// a fill then writes the next free slot and, when the hand wraps, subtracts
// the capacity from it, and a replacement clears each set reference bit the
// hand passes (at most one rotation of the capacity) before it evicts. The
// result is held on result, marked by result_valid for exactly one cycle;
// the receiver cannot stall it, so it must take every result as it appears.
// ----------------------------------------------------------------------------
module clock_replacement_block_cache_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  crbc_pkg::request_t           request,
  output logic                         result_valid,
  output crbc_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crbc_pkg::ADDR_W-1:0]  paddr,
  input  logic [crbc_pkg::DATA_W-1:0]  pwdata,
  output logic [crbc_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import crbc_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_MISS   = 3'd2;
  localparam logic [2:0] ST_WRAP   = 3'd3;
  localparam logic [2:0] ST_SWEEP  = 3'd4;
  localparam logic [2:0] ST_EVICT  = 3'd5;

  logic [2:0]        state;
  logic [CNT_W-1:0]  active_entries;
  logic [CNT_W-1:0]  filled;
  logic [CNT_W-1:0]  hand;
  logic [SLOTS-1:0]  refbit;
  logic [SLOT_W-1:0] idx;
  request_t          req;

  logic [ID_W-1:0]   tag_mem [SLOTS];
  logic [ID_W-1:0]   rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;

  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  hand_step;
  logic              cfg_wr;

  always_comb begin
    if (active_entries == '0) begin
      cap = CNT_W'(1);
    end else if (active_entries > CNT_W'(SLOTS)) begin
      cap = CNT_W'(SLOTS);
    end else begin
      cap = active_entries;
    end
  end

  assign idx_inc   = {1'b0, idx} + CNT_W'(1);
  assign hand_step = (hand + CNT_W'(1) == cap) ? '0 : hand + CNT_W'(1);
  assign busy      = (state != ST_IDLE);
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign prdata    = (paddr == REG_ACTIVE_ENTRIES) ?
                     {{(DATA_W-CNT_W){1'b0}}, active_entries} : '0;

  always_comb begin
    case (state)
      ST_SEARCH: rd_addr = idx_inc[SLOT_W-1:0];
      ST_SWEEP:  rd_addr = hand[SLOT_W-1:0];
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = hand[SLOT_W-1:0];
    case (state)
      ST_MISS: begin
        if (filled < cap) begin
          wr_en   = 1'b1;
          wr_addr = filled[SLOT_W-1:0];
        end
      end
      ST_EVICT: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  // tag RAM, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_addr] <= req.block_num;
    end
    rd_data <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= CNT_W'(SLOTS);
    end else if (cfg_wr && paddr == REG_ACTIVE_ENTRIES) begin
      active_entries <= pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      filled       <= '0;
      hand         <= '0;
      refbit       <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            req   <= request;
            idx   <= '0;
            state <= (filled == '0) ? ST_MISS : ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (rd_data == req.block_num) begin
            if (!req.mode) begin
              refbit[idx] <= 1'b1;
            end
            result_valid <= 1'b1;
            result       <= '{hit: 1'b1, slot: idx, replaced: 1'b0, evicted_block: '0};
            state        <= ST_IDLE;
          end else if (idx_inc < filled) begin
            idx <= idx_inc[SLOT_W-1:0];
          end else begin
            state <= ST_MISS;
          end
        end
        ST_MISS: begin
          if (filled < cap) begin
            refbit[filled[SLOT_W-1:0]] <= 1'b1;
            filled <= filled + CNT_W'(1);
            hand   <= hand + CNT_W'(1);
            result <= '{hit: 1'b0, slot: filled[SLOT_W-1:0], replaced: 1'b0,
                        evicted_block: '0};
            state  <= ST_WRAP;
          end else begin
            if (hand >= cap) begin
              hand <= '0;
            end
            state <= ST_SWEEP;
          end
        end
        ST_WRAP: begin
          if (hand >= cap) begin
            hand <= hand - cap;
          end else begin
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        ST_SWEEP: begin
          if (refbit[hand[SLOT_W-1:0]]) begin
            refbit[hand[SLOT_W-1:0]] <= 1'b0;
            hand <= hand_step;
          end else begin
            state <= ST_EVICT;
          end
        end
        ST_EVICT: begin
          refbit[hand[SLOT_W-1:0]] <= 1'b1;
          hand         <= hand_step;
          result_valid <= 1'b1;
          result       <= '{hit: 1'b0, slot: hand[SLOT_W-1:0], replaced: 1'b1,
                            evicted_block: rd_data};
          state        <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: bench/clock_replacement_block_cache_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_replacement_block_cache_core_tb
// Self-checking bench for the clock replacement block-cache directory. A
// behavioral copy of the directory (tags, reference bits, fill count, hand)
// predicts hit, slot and eviction for every accepted request. Directed tests
// cover fill, read and write hits, full-rotation sweeps, capacity clamps and a
// shrink below the fill level. Randomized phases with mixed capacities and
// sender gaps follow. The APB capacity register is read back after each write.
// ----------------------------------------------------------------------------
module clock_replacement_block_cache_core_tb;
  import crbc_pkg::*;

  localparam int   MAX_CYCLES   = 300000;
  localparam int   DRAIN_CYCLES = 60;
  localparam int   POOL_SIZE    = 20;
  localparam logic MODE_READ    = 1'b0;
  localparam logic MODE_WRITE   = 1'b1;
  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  request_t          request = '0;
  logic              result_valid;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  clock_replacement_block_cache_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directory copy
  logic [ID_W-1:0]  tag_copy [SLOTS];
  logic [SLOTS-1:0] ref_copy = '0;
  int unsigned      fill_copy = 0;
  int unsigned      hand_copy = 0;
  logic [CNT_W-1:0] entries_copy = CNT_W'(SLOTS);

  result_t         pending_lookups [$];
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  int              errors = 0;
  int              items_sent = 0;
  int              hits_seen = 0;
  int              fills_seen = 0;
  int              evictions_seen = 0;
  int              settings_used = 0;
  int              cycle_count = 0;
  bit              gaps_on = 1'b0;

  function automatic result_t clock_lookup(input logic mode, input logic [ID_W-1:0] id);
    result_t     r;
    int unsigned cap;
    int unsigned sweep;
    r = '0;
    cap = (entries_copy == 0) ? 1 : ((entries_copy > SLOTS) ? SLOTS : entries_copy);
    for (int i = 0; i < fill_copy; i++) begin
      if (tag_copy[i] == id) begin
        if (mode == MODE_READ) ref_copy[i] = 1'b1;
        r.hit  = 1'b1;
        r.slot = SLOT_W'(i);
        return r;
      end
    end
    if (fill_copy < cap) begin
      r.slot = SLOT_W'(fill_copy);
      tag_copy[fill_copy] = id;
      ref_copy[fill_copy] = 1'b1;
      fill_copy++;
      hand_copy = (hand_copy + 1) % cap;
      return r;
    end
    if (hand_copy >= cap) hand_copy = 0;
    sweep = 0;
    while (ref_copy[hand_copy] && sweep < 2 * cap) begin
      ref_copy[hand_copy] = 1'b0;
      hand_copy = (hand_copy + 1) % cap;
      sweep++;
    end
    r.slot          = SLOT_W'(hand_copy);
    r.replaced      = 1'b1;
    r.evicted_block = tag_copy[hand_copy];
    tag_copy[hand_copy] = id;
    ref_copy[hand_copy] = 1'b1;
    hand_copy = (hand_copy + 1) % cap;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected result slot", 32'(result.slot), '0);
      end else begin
        want = pending_lookups.pop_front();
        if (result.hit !== want.hit)
          report_mismatch("hit", 32'(result.hit), 32'(want.hit));
        if (result.slot !== want.slot)
          report_mismatch("slot", 32'(result.slot), 32'(want.slot));
        if (result.replaced !== want.replaced)
          report_mismatch("replaced", 32'(result.replaced), 32'(want.replaced));
        if (result.evicted_block !== want.evicted_block)
          report_mismatch("evicted_block", 32'(result.evicted_block),
                          32'(want.evicted_block));
        if (want.hit) hits_seen++;
        else if (want.replaced) evictions_seen++;
        else fills_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results pending",
               cycle_count, pending_lookups.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_request(input logic mode, input logic [ID_W-1:0] id);
    @(negedge clk);
    start   <= 1'b1;
    request <= '{mode: mode, block_num: id};
    do @(posedge clk); while (busy);
    pending_lookups.insert(pending_lookups.size(), clock_lookup(mode, id));
    items_sent++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic random_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 8)) @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_lookups.size() != 0 || busy) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic read_entries(output logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= REG_ACTIVE_ENTRIES;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write the capacity register (upper data bits random) and read it back
  task automatic program_capacity(input logic [CNT_W-1:0] entries);
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] readback;
    value = {(DATA_W-CNT_W)'($urandom()), entries};
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ACTIVE_ENTRIES;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    entries_copy = value[CNT_W-1:0];
    settings_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    read_entries(readback);
    if (readback !== DATA_W'(entries)) report_mismatch("active_entries readback", readback,
                                                       DATA_W'(entries));
  endtask

  task automatic test_register_reset();
    logic [DATA_W-1:0] readback;
    read_entries(readback);
    if (readback !== DATA_W'(SLOTS))
      report_mismatch("active_entries reset", readback, DATA_W'(SLOTS));
  endtask

  // three slots: fill, hits of both kinds, full-rotation sweep, replacements
  task automatic test_small_fill_and_sweep();
    program_capacity(CNT_W'(3));
    send_request(MODE_READ, '0);
    send_request(MODE_WRITE, ID_MAX);
    send_request(MODE_READ, 31'h2AAA_AAAA);
    send_request(MODE_READ, '0);
    send_request(MODE_WRITE, ID_MAX);
    send_request(MODE_READ, 31'h5555_5555);
    send_request(MODE_WRITE, '0);
    send_request(MODE_READ, '0);
    send_request(MODE_READ, 31'h2AAA_AAAA);
    send_request(MODE_WRITE, 31'h1234_5678);
  endtask

  // zero acts as one slot with the hand wrapped; hits above capacity;
  // values above SLOTS act as SLOTS and resume filling
  task automatic test_capacity_clamps();
    program_capacity(CNT_W'(0));
    send_request(MODE_READ, ID_MAX);
    send_request(MODE_READ, '0);
    send_request(MODE_WRITE, ID_MAX);
    send_request(MODE_READ, 31'h2AAA_AAAA);
    program_capacity(CNT_W'(31));
    send_request(MODE_WRITE, 31'h0000_0001);
    send_request(MODE_READ, 31'h4000_0000);
    send_request(MODE_READ, 31'h3FFF_FFFF);
    send_request(MODE_WRITE, ID_W'($urandom()));
    send_request(MODE_READ, 31'h0000_0001);
  endtask

  task automatic random_phase(input logic [CNT_W-1:0] entries, input int count,
                              input bit pause_midway);
    logic [ID_W-1:0] id;
    int unsigned     pick;
    program_capacity(entries);
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom());
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45 && fill_copy != 0) id = tag_copy[$urandom_range(0, fill_copy - 1)];
      else if (pick < 85) id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 90) id = pick[0] ? ID_MAX : '0;
      else id = ID_W'($urandom());
      send_request(logic'($urandom_range(0, 1)), id);
      if (pause_midway && n == count / 2) wait_drained();
      random_gap();
    end
  endtask

  task automatic test_random_traffic();
    gaps_on = 1'b1;
    random_phase(CNT_W'(16), 55, 1'b0);
    random_phase(CNT_W'(7), 55, 1'b1);
    random_phase(CNT_W'(1), 50, 1'b0);
    random_phase(CNT_W'(17), 55, 1'b0);
    random_phase(CNT_W'(2), 50, 1'b0);
    random_phase(CNT_W'(0), 40, 1'b0);
    random_phase(CNT_W'($urandom_range(3, 15)), 60, 1'b0);
    gaps_on = 1'b0;
    random_phase(CNT_W'(16), 75, 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_register_reset();
    test_small_fill_and_sweep();
    test_capacity_clamps();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Ran %0d requests over %0d capacity settings: %0d hits, %0d fills, %0d evictions",
             items_sent, settings_used, hits_seen, fills_seen, evictions_seen);
    $display("Mismatches found: %0d", errors);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/crbc_pkg.sv
hw/rtl/clock_replacement_block_cache_core.sv
bench/clock_replacement_block_cache_core_tb.sv
